[rtl/core/html_tag_stripper_macros.svh]
// Assertion macros shared by the tag stripper RTL.
// No dependencies; included inside module bodies.
`ifndef HTML_TAG_STRIPPER_MACROS_SVH
`define HTML_TAG_STRIPPER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HTS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hts assertion failed");

// Next-cycle implication, checked outside reset.
`define HTS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hts assertion failed");

`endif

[rtl/core/hts_pkg.sv]
// Shared types, parser mode codes and character constants for the tag stripper.
// No dependencies.
package hts_pkg;

    localparam logic [3:0] MODE_TEXT    = 4'd0;
    localparam logic [3:0] MODE_LT      = 4'd1;
    localparam logic [3:0] MODE_TAG     = 4'd2;
    localparam logic [3:0] MODE_SKIP    = 4'd3;
    localparam logic [3:0] MODE_SKIP_LT = 4'd4;
    localparam logic [3:0] MODE_CLOSE   = 4'd5;
    localparam logic [3:0] MODE_BANG0   = 4'd6;
    localparam logic [3:0] MODE_BANG1   = 4'd7;
    localparam logic [3:0] MODE_BANG2   = 4'd8;
    localparam logic [3:0] MODE_DECL    = 4'd9;

    localparam int unsigned NAME_MAX = 6;
    localparam logic [2:0]  NAME_LEN_MAX  = 3'd6;
    localparam logic [2:0]  NAME_TOO_LONG = 3'd7;
    localparam logic [2:0]  LEN_SCRIPT    = 3'd6;
    localparam logic [2:0]  LEN_STYLE     = 3'd5;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    // Name bytes, byte 0 in the lowest (rightmost) slot of each literal.
    localparam logic [5:0][7:0] WORD_SCRIPT = {8'h74, 8'h70, 8'h69, 8'h72, 8'h63, 8'h73};
    localparam logic [5:0][7:0] WORD_STYLE  = {8'h00, 8'h65, 8'h6C, 8'h79, 8'h74, 8'h73};

    typedef logic [5:0][7:0] name_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } emit_t;

    function automatic logic is_punct(input logic [7:0] b);
        logic r;
        r = 1'b0;
        case (b) inside
            8'h2E, 8'h2C, 8'h28, 8'h5B, 8'h7B, 8'h29, 8'h5D, 8'h7D,
            8'h3A, 8'h3B, 8'h22: r = 1'b1;
            default:             r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/html_tag_stripper.sv]
// Tag stripper: turns an HTML byte stream into its plain text.
// Ports carry one item each way with valid/ready handshakes.
//
// Input channel s_*: one source byte per item (s_in_byte).
// Result channel m_*: one text byte per item (m_out_byte); m_last_of_run
// marks the last result caused by one input byte. An input byte causes
// zero, one or two results: markup and non-printing bytes cause none, a
// text newline gives one space per run, punctuation a newline and a space.
// Path: an accepted input byte goes into the input register, then the
// parser maps it into the result queue, whose head item drives m_*.
// Throughput: one input byte per cycle while results are taken every cycle;
// a steady run of punctuation is slowed by the single-item output port,
// since each such byte causes two results.
// Stall: when m_ready is low the result queue (QUEUE_DEPTH items) fills;
// once it cannot take two more results the input register holds and
// s_ready drops; it resumes without loss as soon as there is room.
// Nothing is dropped or repeated.
// Reset (aresetn low, synchronous): parser returns to text mode, name and
// newline tracking clear, queue and input register empty.
module html_tag_stripper #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last_of_run
);
    import hts_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       room;
    logic       step;
    emit_t      emit;

    assign step    = in_valid_reg && room;
    assign s_ready = !in_valid_reg || room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_byte_reg <= s_in_byte;
    end

    hts_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_byte (in_byte_reg),
        .emit    (emit)
    );

    hts_out_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (step),
        .emit          (emit),
        .room          (room),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

endmodule

[rtl/core/hts_parser.sv]
// Parser state machine and text mapping for the tag stripper.
// Depends on hts_pkg and html_tag_stripper_macros.svh.
module hts_parser (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           step,
    input  logic [7:0]     in_byte,
    output hts_pkg::emit_t emit
);
    import hts_pkg::*;
    `include "html_tag_stripper_macros.svh"

    logic [3:0] mode_reg, mode_next;
    name_t      chars_reg, chars_next;
    logic [2:0] len_reg, len_next;
    logic       stopped_reg, stopped_next;
    logic       nl_reg, nl_next;

    name_t      app_chars;
    logic [2:0] app_len;
    logic       app_stopped;
    logic       name_match;

    // One name byte appended to the collected name.
    always_comb begin
        app_chars   = chars_reg;
        app_len     = len_reg;
        app_stopped = stopped_reg;
        if (!stopped_reg) begin
            if (in_byte == CH_NUL) begin
                app_stopped = 1'b1;
            end else if (len_reg < NAME_LEN_MAX) begin
                for (int i = 0; i < NAME_MAX; i++) begin
                    if (len_reg == 3'(i)) app_chars[i] = in_byte;
                end
                app_len = len_reg + 3'd1;
            end else begin
                app_len = NAME_TOO_LONG;
            end
        end
    end

    assign name_match = (len_reg == LEN_SCRIPT && chars_reg == WORD_SCRIPT) ||
                        (len_reg == LEN_STYLE  && chars_reg == WORD_STYLE);

    always_comb begin
        mode_next    = mode_reg;
        chars_next   = chars_reg;
        len_next     = len_reg;
        stopped_next = stopped_reg;
        nl_next      = nl_reg;
        emit         = '0;
        unique case (mode_reg)
            MODE_LT: begin
                if (in_byte == CH_BANG) begin
                    mode_next = MODE_BANG0;
                end else begin
                    chars_next    = '0;
                    chars_next[0] = in_byte;
                    len_next      = (in_byte == CH_NUL) ? 3'd0 : 3'd1;
                    stopped_next  = (in_byte == CH_NUL);
                    mode_next     = MODE_TAG;
                end
            end
            MODE_TAG: begin
                if (in_byte == CH_GT) begin
                    mode_next = name_match ? MODE_SKIP : MODE_TEXT;
                end else if (in_byte == CH_SPACE || in_byte == CH_NL) begin
                    stopped_next = 1'b1;
                end else begin
                    chars_next   = app_chars;
                    len_next     = app_len;
                    stopped_next = app_stopped;
                end
            end
            MODE_SKIP: begin
                if (in_byte == CH_LT) mode_next = MODE_SKIP_LT;
            end
            MODE_SKIP_LT: begin
                if (in_byte == CH_SLASH) begin
                    chars_next   = '0;
                    len_next     = 3'd0;
                    stopped_next = 1'b0;
                    mode_next    = MODE_CLOSE;
                end else begin
                    mode_next = MODE_SKIP;
                end
            end
            MODE_CLOSE: begin
                if (in_byte == CH_GT) begin
                    mode_next = name_match ? MODE_TEXT : MODE_SKIP;
                end else begin
                    chars_next   = app_chars;
                    len_next     = app_len;
                    stopped_next = app_stopped;
                end
            end
            MODE_BANG0: begin
                if (in_byte == CH_DASH || in_byte == CH_D) mode_next = MODE_BANG1;
            end
            MODE_BANG1: begin
                mode_next = (in_byte == CH_DASH || in_byte == CH_O) ? MODE_BANG2 : MODE_BANG0;
            end
            MODE_BANG2: begin
                if (in_byte == CH_GT)     mode_next = MODE_TEXT;
                else if (in_byte == CH_C) mode_next = MODE_DECL;
                else                      mode_next = MODE_BANG0;
            end
            MODE_DECL: begin
                if (in_byte == CH_GT) mode_next = MODE_TEXT;
            end
            default: begin
                // text mode; unreachable codes behave the same
                mode_next = MODE_TEXT;
                if (in_byte == CH_LT) begin
                    mode_next = MODE_LT;
                end else if (in_byte == CH_NL) begin
                    if (!nl_reg) begin
                        nl_next      = 1'b1;
                        emit.count   = 2'd1;
                        emit.first   = '{out_byte: CH_SPACE, last_of_run: 1'b1};
                    end
                end else begin
                    nl_next = 1'b0;
                    if (in_byte >= CH_SPACE && in_byte <= CH_TILDE) begin
                        if (is_punct(in_byte)) begin
                            emit.count  = 2'd2;
                            emit.first  = '{out_byte: CH_NL, last_of_run: 1'b0};
                            emit.second = '{out_byte: CH_SPACE, last_of_run: 1'b1};
                        end else begin
                            emit.count  = 2'd1;
                            emit.first  = '{out_byte: in_byte, last_of_run: 1'b1};
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_TEXT;
            chars_reg   <= '0;
            len_reg     <= 3'd0;
            stopped_reg <= 1'b0;
            nl_reg      <= 1'b0;
        end else if (step) begin
            mode_reg    <= mode_next;
            chars_reg   <= chars_next;
            len_reg     <= len_next;
            stopped_reg <= stopped_next;
            nl_reg      <= nl_next;
        end
    end

    `HTS_ASSERT_NOW(a_mode_known, aclk, aresetn, 1'b1, mode_reg <= MODE_DECL)
    `HTS_ASSERT_NOW(a_emit_only_text, aclk, aresetn, emit.count != 2'd0,
        mode_reg == MODE_TEXT)
    `HTS_ASSERT_NEXT(a_hold_when_idle, aclk, aresetn, !step,
        $stable(mode_reg) && $stable(len_reg) && $stable(nl_reg))

endmodule

[rtl/core/hts_out_queue.sv]
// Result queue: takes up to two result items per cycle, hands out one.
// Depends on hts_pkg and html_tag_stripper_macros.svh.
module hts_out_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  hts_pkg::emit_t   emit,
    output logic             room,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_last_of_run
);
    import hts_pkg::*;
    `include "html_tag_stripper_macros.svh"

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    result_t    data_reg [DEPTH];
    result_t    data_next [DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] base;
    logic [CNT_W-1:0] push_n;
    logic             pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != '0);
    assign m_out_byte    = data_reg[0].out_byte;
    assign m_last_of_run = data_reg[0].last_of_run;

    assign base   = count_reg - CNT_W'(pop);
    assign room   = (base <= CNT_W'(DEPTH - 2));
    assign push_n = push ? CNT_W'(emit.count) : '0;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (pop && i < DEPTH - 1) data_next[i] = data_reg[i + 1];
            else                      data_next[i] = data_reg[i];
            if (push_n != '0 && base == CNT_W'(i))
                data_next[i] = emit.first;
            if (push_n == CNT_W'(2) && base + CNT_W'(1) == CNT_W'(i))
                data_next[i] = emit.second;
        end
        count_next = base + push_n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) data_reg[i] <= data_next[i];
    end

    `HTS_ASSERT_NOW(a_no_overflow, aclk, aresetn, push,
        base + push_n <= CNT_W'(DEPTH))
    `HTS_ASSERT_NEXT(a_count_track, aclk, aresetn, !pop,
        count_reg == $past(count_reg) + $past(push_n))
    `HTS_ASSERT_NOW(a_fall_on_pop, aclk, aresetn, $fell(m_valid), $past(pop))

endmodule
